>>> rtl/gda_pkg.sv
`timescale 1ns / 1ps
// gda_pkg: constants, types and calendar helper functions for the gregorian date block
// used by gda_ctrl, gda_dp and the top level gregorian_date_arithmetic

package gda_pkg;

  // field widths fixed by the stream word layout
  localparam int YEAR_W = 14;
  localparam int MON_W  = 4;
  localparam int DAY_W  = 5;
  localparam int OFF_W  = 23;
  localparam int CMD_W  = 2;

  localparam int IN_DATA_W  = 72;  // 69 field bits padded to whole bytes
  localparam int OUT_DATA_W = 48;  // 48 field bits

  localparam int MAX_YEAR = 9999;

  // internal year width covers both the input field and the top year
  localparam int YY_W = ($clog2(MAX_YEAR + 2) > YEAR_W) ? $clog2(MAX_YEAR + 2) : YEAR_W;

  // day number of the last day of MAX_YEAR, 0001-01-01 being day 0
  localparam int LAST_DAY = MAX_YEAR * 365 + MAX_YEAR / 4 - MAX_YEAR / 100
                            + MAX_YEAR / 400 - 1;
  localparam int DN_W  = $clog2(LAST_DAY + 1);
  localparam int SUM_W = ((DN_W > OFF_W) ? DN_W : OFF_W) + 2;

  localparam int CYCLE_DAYS  = 146097;
  localparam int CYCLE_YEARS = 400;

  // reciprocal of 100, exact floor for values below about 199000
  localparam int REC_SH  = 24;
  localparam int REC_100 = 167773;

  localparam int DOY_W = 9;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD  = 2'd0,
    CMD_SUB  = 2'd1,
    CMD_DIFF = 2'd2,
    CMD_CMP  = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_A,
    ST_SUM_A,
    ST_MUL_B,
    ST_SUM_B,
    ST_ADD,
    ST_CYCLE,
    ST_YEAR,
    ST_MONTH,
    ST_DONE
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic mul;
    logic sel_b;
    logic sum;
    logic add;
    logic cyc;
    logic year;
    logic month;
    logic load;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic date_ok;
    logic is_date_cmd;
    logic range_bad;
    logic cyc_ge;
    logic year_ge;
    logic month_ge;
  } dp_sts_t;

  function automatic logic [YY_W-1:0] div100(input logic [YY_W-1:0] y);
    logic [YY_W+REC_SH-1:0] prod;
    prod = (YY_W + REC_SH)'(y) * (YY_W + REC_SH)'(REC_100);
    return prod[REC_SH +: YY_W];
  endfunction

  function automatic logic leap_year(input logic [YY_W-1:0] y);
    logic [YY_W-1:0] q;
    logic [YY_W-1:0] r;
    q = div100(y);
    r = y - YY_W'(q * YY_W'(100));
    return ((y[1:0] == 2'd0) && (r != '0)) || ((r == '0) && (q[1:0] == 2'd0));
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic leap, input logic [MON_W-1:0] m);
    logic [DAY_W-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:    len = leap ? 5'd29 : 5'd28;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

  // days before the first of month m in a common year
  function automatic logic [DOY_W-1:0] cum_days(input logic [MON_W-1:0] m);
    logic [DOY_W-1:0] c;
    case (m)
      4'd1:    c = 9'd0;
      4'd2:    c = 9'd31;
      4'd3:    c = 9'd59;
      4'd4:    c = 9'd90;
      4'd5:    c = 9'd120;
      4'd6:    c = 9'd151;
      4'd7:    c = 9'd181;
      4'd8:    c = 9'd212;
      4'd9:    c = 9'd243;
      4'd10:   c = 9'd273;
      4'd11:   c = 9'd304;
      4'd12:   c = 9'd334;
      default: c = 9'd0;
    endcase
    return c;
  endfunction

  function automatic logic date_valid(input logic [YEAR_W-1:0] y, input logic [MON_W-1:0] m,
                                      input logic [DAY_W-1:0] d);
    logic [YY_W-1:0] yy;
    logic            ok;
    yy = YY_W'(y);
    ok = (yy >= YY_W'(1)) && (yy <= YY_W'(MAX_YEAR)) && (m >= 4'd1) && (m <= 4'd12)
         && (d >= 5'd1) && (d <= month_len(leap_year(yy), m));
    return ok;
  endfunction

endpackage

>>> rtl/gda_ctrl.sv
`timescale 1ns / 1ps
// gda_ctrl: sequencer for the gregorian date block
// depends on gda_pkg; drives gda_dp through dp_cmd_t and reads dp_sts_t

module gda_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  gda_pkg::dp_sts_t sts_i,
  output gda_pkg::dp_cmd_t cmd_o
);
  import gda_pkg::*;

  state_e state_q, state_d;
  logic   ov_q, ov_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_MUL_A;
        end
      end
      ST_MUL_A: begin
        if (!sts_i.date_ok) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.mul = 1'b1;
          state_d   = ST_SUM_A;
        end
      end
      ST_SUM_A: begin
        cmd_o.sum = 1'b1;
        state_d   = sts_i.is_date_cmd ? ST_ADD : ST_MUL_B;
      end
      ST_MUL_B: begin
        cmd_o.mul   = 1'b1;
        cmd_o.sel_b = 1'b1;
        state_d     = ST_SUM_B;
      end
      ST_SUM_B: begin
        cmd_o.sum   = 1'b1;
        cmd_o.sel_b = 1'b1;
        state_d     = ST_DONE;
      end
      ST_ADD: begin
        cmd_o.add = 1'b1;
        state_d   = sts_i.range_bad ? ST_DONE : ST_CYCLE;
      end
      ST_CYCLE: begin
        if (sts_i.cyc_ge) begin
          cmd_o.cyc = 1'b1;
        end else begin
          state_d = ST_YEAR;
        end
      end
      ST_YEAR: begin
        if (sts_i.year_ge) begin
          cmd_o.year = 1'b1;
        end else begin
          state_d = ST_MONTH;
        end
      end
      ST_MONTH: begin
        if (sts_i.month_ge) begin
          cmd_o.month = 1'b1;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!ov_q || out_ready_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ov_d = ov_q;
    if (cmd_o.load) begin
      ov_d = 1'b1;
    end else if (out_ready_i) begin
      ov_d = 1'b0;
    end
  end

  assign out_valid_o = ov_q;

endmodule

>>> rtl/gda_dp.sv
`timescale 1ns / 1ps
// gda_dp: datapath of the gregorian date block (day numbers, offset, date decomposition)
// depends on gda_pkg; sequenced by gda_ctrl

module gda_dp (
  input  logic                           clk_i,
  input  logic [gda_pkg::IN_DATA_W-1:0]  in_data_i,
  input  logic [gda_pkg::CMD_W-1:0]      in_user_i,
  input  gda_pkg::dp_cmd_t               cmd_i,
  output gda_pkg::dp_sts_t               sts_o,
  output logic [gda_pkg::OUT_DATA_W-1:0] out_data_o,
  output logic                           out_err_o
);
  import gda_pkg::*;

  cmd_e                 op_q;
  logic [YEAR_W-1:0]    ya_q, yb_q;
  logic [MON_W-1:0]     ma_q, mb_q;
  logic [DAY_W-1:0]     da_q, db_q;
  logic signed [OFF_W-1:0] off_q;

  logic [YY_W-1:0]      p_q;
  logic [DN_W-1:0]      p365_q;
  logic [YY_W-1:0]      q100_q;
  logic [DOY_W-1:0]     doy_q;
  logic [DN_W-1:0]      na_q, nb_q;

  logic                 rbad_q;
  logic [DN_W-1:0]      r_q;
  logic [YY_W-1:0]      yy_q;
  logic [MON_W-1:0]     mm_q;
  logic                 leap_q;

  logic [OUT_DATA_W-1:0] out_q;
  logic                  err_q;

  // date validity
  logic va, vb, date_ok, is_date;
  assign va      = date_valid(ya_q, ma_q, da_q);
  assign vb      = date_valid(yb_q, mb_q, db_q);
  assign is_date = (op_q == CMD_ADD) || (op_q == CMD_SUB);
  assign date_ok = is_date ? va : (va && vb);

  // day number, first half: products
  logic [YEAR_W-1:0]     y_sel;
  logic [MON_W-1:0]      m_sel;
  logic [DAY_W-1:0]      d_sel;
  logic [YY_W-1:0]       p;
  logic [YY_W+9-1:0]     p365;
  logic [DOY_W-1:0]      doy;
  assign y_sel = cmd_i.sel_b ? yb_q : ya_q;
  assign m_sel = cmd_i.sel_b ? mb_q : ma_q;
  assign d_sel = cmd_i.sel_b ? db_q : da_q;
  assign p     = YY_W'(y_sel) - YY_W'(1);
  assign p365  = (YY_W + 9)'(p) * (YY_W + 9)'(365);
  assign doy   = cum_days(m_sel)
                 + DOY_W'(leap_year(YY_W'(y_sel)) && (m_sel > 4'd2))
                 + DOY_W'(d_sel) - DOY_W'(1);

  // day number, second half: sum
  logic [DN_W-1:0] dn_sum;
  assign dn_sum = p365_q + DN_W'(p_q >> 2) - DN_W'(q100_q) + DN_W'(q100_q >> 2)
                  + DN_W'(doy_q);

  // offset applied to date A
  logic signed [SUM_W-1:0] n_new;
  logic signed [SUM_W-1:0] off_ext;
  logic                    range_bad;
  assign off_ext   = SUM_W'(off_q);
  assign n_new     = (op_q == CMD_ADD) ? ($signed(SUM_W'(na_q)) + off_ext)
                                       : ($signed(SUM_W'(na_q)) - off_ext);
  assign range_bad = (n_new < 0) || (n_new > $signed(SUM_W'(LAST_DAY)));

  // decomposition steps
  logic [DN_W-1:0]  ylen;
  logic [DN_W-1:0]  mlen;
  logic [YY_W-1:0]  yy_next;
  assign ylen    = leap_q ? DN_W'(366) : DN_W'(365);
  assign mlen    = DN_W'(month_len(leap_q, mm_q));
  assign yy_next = yy_q + YY_W'(1);

  assign sts_o.date_ok     = date_ok;
  assign sts_o.is_date_cmd = is_date;
  assign sts_o.range_bad   = range_bad;
  assign sts_o.cyc_ge      = r_q >= DN_W'(CYCLE_DAYS);
  assign sts_o.year_ge     = r_q >= ylen;
  assign sts_o.month_ge    = r_q >= mlen;

  // result formation
  localparam logic signed [SUM_W-1:0] DIFF_MAX = SUM_W'(2 ** (OFF_W - 1) - 1);
  localparam logic signed [SUM_W-1:0] DIFF_MIN = -SUM_W'(2 ** (OFF_W - 1));
  logic signed [SUM_W-1:0] diff_full;
  logic [OFF_W-1:0]        diff;
  logic                    sat;
  logic [YEAR_W-1:0]       res_year;
  logic [MON_W-1:0]        res_month;
  logic [DAY_W-1:0]        res_day;
  logic [OFF_W-1:0]        res_diff;
  logic                    res_eq, res_gt, res_err;
  logic                    date_res;

  assign diff_full = $signed(SUM_W'(na_q)) - $signed(SUM_W'(nb_q));
  assign sat       = (diff_full > DIFF_MAX) || (diff_full < DIFF_MIN);

  always_comb begin
    if (diff_full > DIFF_MAX) begin
      diff = DIFF_MAX[OFF_W-1:0];
    end else if (diff_full < DIFF_MIN) begin
      diff = DIFF_MIN[OFF_W-1:0];
    end else begin
      diff = diff_full[OFF_W-1:0];
    end
  end

  assign date_res  = is_date && date_ok && !rbad_q;
  assign res_year  = date_res ? yy_q[YEAR_W-1:0] : '0;
  assign res_month = date_res ? mm_q : '0;
  assign res_day   = date_res ? (DAY_W'(r_q) + DAY_W'(1)) : '0;
  assign res_diff  = (date_ok && (op_q == CMD_DIFF)) ? diff : '0;
  assign res_eq    = date_ok && (op_q == CMD_CMP) && (na_q == nb_q);
  assign res_gt    = date_ok && (op_q == CMD_CMP) && (na_q > nb_q);
  assign res_err   = !date_ok || (is_date && rbad_q) || ((op_q == CMD_DIFF) && sat);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= cmd_e'(in_user_i);
      ya_q   <= in_data_i[13:0];
      ma_q   <= in_data_i[17:14];
      da_q   <= in_data_i[22:18];
      yb_q   <= in_data_i[36:23];
      mb_q   <= in_data_i[40:37];
      db_q   <= in_data_i[45:41];
      off_q  <= in_data_i[68:46];
      rbad_q <= 1'b0;
    end
    if (cmd_i.mul) begin
      p_q    <= p;
      p365_q <= DN_W'(p365);
      q100_q <= div100(p);
      doy_q  <= doy;
    end
    if (cmd_i.sum) begin
      if (cmd_i.sel_b) begin
        nb_q <= dn_sum;
      end else begin
        na_q <= dn_sum;
      end
    end
    if (cmd_i.add) begin
      rbad_q <= range_bad;
      r_q    <= n_new[DN_W-1:0];
      yy_q   <= YY_W'(1);
      mm_q   <= 4'd1;
      leap_q <= 1'b0;
    end
    if (cmd_i.cyc) begin
      r_q  <= r_q - DN_W'(CYCLE_DAYS);
      yy_q <= yy_q + YY_W'(CYCLE_YEARS);
    end
    if (cmd_i.year) begin
      r_q    <= r_q - ylen;
      yy_q   <= yy_next;
      leap_q <= leap_year(yy_next);
    end
    if (cmd_i.month) begin
      r_q  <= r_q - mlen;
      mm_q <= mm_q + 4'd1;
    end
    if (cmd_i.load) begin
      out_q <= {res_gt, res_eq, res_diff, res_day, res_month, res_year};
      err_q <= res_err;
    end
  end

  assign out_data_o = out_q;
  assign out_err_o  = err_q;

endmodule

>>> rtl/gregorian_date_arithmetic.sv
`timescale 1ns / 1ps
// gregorian_date_arithmetic: top level of the gregorian date add, subtract, difference
// and compare block; depends on gda_pkg, gda_ctrl and gda_dp
//
// usage
//   one request word goes in on the s_axis side, one result word comes out on the
//   m_axis side. s_axis_tuser carries the command (add, subtract, difference, compare),
//   m_axis_tuser carries the error flag.
//   dates are turned into day numbers counted from 0001-01-01; add and subtract then
//   split the moved day number back into a date by 400-year steps, single-year steps
//   and month steps, one step a cycle in the datapath.
// sequence and throughput
//   difference and compare: products and sum for date A, then for date B, then the result.
//   add and subtract: products and sum for date A, the offset add, then at most 24
//   four-century steps, 399 year steps and 11 month steps before the result is loaded.
//   an invalid date ends before the products, an out-of-range result right after the add.
//   one request word is in flight at a time; s_axis_tready is high only when idle,
//   so the next word is taken at the earliest in the idle state after the result is loaded.
// reset
//   rst_ni clears the sequencer and the output valid flag; no result is pending.
// stalls
//   the result sits in an output register; the next request word is accepted while it
//   waits. a finished result waits in the sequencer until the output register is free.

module gregorian_date_arithmetic (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // tdata, lowest bit up: year_a[13:0], month_a[17:14], day_a[22:18], year_b[36:23],
  // month_b[40:37], day_b[45:41], day_offset[68:46], zero padding[71:69]
  input  logic [gda_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  // tuser: cmd[1:0]
  input  logic [gda_pkg::CMD_W-1:0]      s_axis_tuser_i,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // tdata, lowest bit up: res_year[13:0], res_month[17:14], res_day[22:18],
  // day_diff[45:23], is_equal[46], is_greater[47]
  output logic [gda_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  // tuser: error[0]
  output logic                           m_axis_tuser_o,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i
);
  import gda_pkg::*;

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  // sequencer: one state per datapath step, with separate product and sum states for dates A and B
  gda_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .sts_i       (dp_sts),
    .cmd_o       (dp_cmd)
  );

  // datapath: request capture, day numbers, offset, decomposition, output word
  gda_dp u_dp (
    .clk_i      (clk_i),
    .in_data_i  (s_axis_tdata_i),
    .in_user_i  (s_axis_tuser_i),
    .cmd_i      (dp_cmd),
    .sts_o      (dp_sts),
    .out_data_o (m_axis_tdata_o),
    .out_err_o  (m_axis_tuser_o)
  );

endmodule

>>> bench/gregorian_date_arithmetic_tb.sv
`timescale 1ns / 1ps
// gregorian_date_arithmetic_tb: self-checking bench for the gregorian date block, a directed
// table followed by constrained-by-hand random request words; depends on gda_pkg and
// gregorian_date_arithmetic

module gregorian_date_arithmetic_tb;
  import gda_pkg::*;

  localparam int DAYS_PER_400Y = 146097;
  localparam int DIFF_TOP      = 4194303;
  localparam int DIFF_BOTTOM   = -4194304;
  localparam int RANDOM_WORDS  = 1150;
  localparam int TAIL_CYCLES   = 64;
  localparam int REPORT_LIMIT  = 10;

  typedef struct packed {
    logic [YEAR_W-1:0] year;
    logic [MON_W-1:0]  month;
    logic [DAY_W-1:0]  day;
  } date_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    date_t            a;
    date_t            b;
    logic [OFF_W-1:0] offset;
  } date_req_t;

  typedef struct packed {
    logic [YEAR_W-1:0] year;
    logic [MON_W-1:0]  month;
    logic [DAY_W-1:0]  day;
    logic [OFF_W-1:0]  diff;
    logic              equal;
    logic              greater;
    logic              err;
  } date_result_t;

  typedef struct packed {
    date_req_t    req;
    logic         typed;  // expectation written into the table by hand
    date_result_t want;
  } directed_row_t;

  logic                  clk_i           = 1'b0;
  logic                  rst_ni          = 1'b0;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i  = '0;
  logic [CMD_W-1:0]      s_axis_tuser_i  = CMD_ADD;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  logic                  m_axis_tuser_o;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;

  date_result_t  awaited_results[$];
  directed_row_t directed_rows[$];
  int            mismatch_count = 0;
  int            tx_idle_pct    = 30;
  int            rx_idle_pct    = 30;

  gregorian_date_arithmetic dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i)
  );

  always #2 clk_i = ~clk_i;

  // ---------------------------------------------------------------- calendar predictor

  function automatic bit is_leap(int y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int days_in_month(int y, int m);
    int len;
    case (m)
      1, 3, 5, 7, 8, 10, 12: len = 31;
      4, 6, 9, 11:           len = 30;
      2:                     len = is_leap(y) ? 29 : 28;
      default:               len = 0;
    endcase
    return len;
  endfunction

  function automatic int year_days(int y);
    return is_leap(y) ? 366 : 365;
  endfunction

  function automatic bit date_is_real(int y, int m, int d);
    return (y >= 1) && (y <= MAX_YEAR) && (m >= 1) && (m <= 12)
           && (d >= 1) && (d <= days_in_month(y, m));
  endfunction

  // days since 0001-01-01
  function automatic longint day_index(int y, int m, int d);
    longint p;
    longint n;
    int     k;
    p = y - 1;
    n = p * 365 + p / 4 - p / 100 + p / 400;
    for (k = 1; k < m; k++) n += days_in_month(y, k);
    return n + d - 1;
  endfunction

  function automatic date_result_t calc_date_result(date_req_t q);
    date_result_t r;
    longint       na;
    longint       nb;
    longint       n;
    longint       rem;
    longint       delta;
    int           y;
    int           m;
    r = '0;
    if (q.cmd == CMD_ADD || q.cmd == CMD_SUB) begin
      if (!date_is_real(q.a.year, q.a.month, q.a.day)) begin
        r.err = 1'b1;
      end else begin
        delta = $signed(q.offset);
        n = day_index(q.a.year, q.a.month, q.a.day) + ((q.cmd == CMD_ADD) ? delta : -delta);
        if (n < 0 || n > day_index(MAX_YEAR, 12, 31)) begin
          r.err = 1'b1;
        end else begin
          // four-century steps, then years, then months
          y   = int'(n / DAYS_PER_400Y) * 400 + 1;
          rem = n % DAYS_PER_400Y;
          m   = 1;
          while (rem >= year_days(y)) begin
            rem -= year_days(y);
            y++;
          end
          while (rem >= days_in_month(y, m)) begin
            rem -= days_in_month(y, m);
            m++;
          end
          r.year  = YEAR_W'(y);
          r.month = MON_W'(m);
          r.day   = DAY_W'(rem + 1);
        end
      end
    end else if (!date_is_real(q.a.year, q.a.month, q.a.day)
                 || !date_is_real(q.b.year, q.b.month, q.b.day)) begin
      r.err = 1'b1;
    end else begin
      na = day_index(q.a.year, q.a.month, q.a.day);
      nb = day_index(q.b.year, q.b.month, q.b.day);
      if (q.cmd == CMD_DIFF) begin
        n = na - nb;
        // saturation only reachable with a much larger top year
        if (n > DIFF_TOP) begin
          n     = DIFF_TOP;
          r.err = 1'b1;
        end
        if (n < DIFF_BOTTOM) begin
          n     = DIFF_BOTTOM;
          r.err = 1'b1;
        end
        r.diff = n[OFF_W-1:0];
      end else begin
        r.equal   = (na == nb);
        r.greater = (na > nb);
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- table helpers

  function automatic date_t dt(int y, int m, int d);
    date_t v;
    v.year  = YEAR_W'(y);
    v.month = MON_W'(m);
    v.day   = DAY_W'(d);
    return v;
  endfunction

  function automatic date_result_t date_out(int y, int m, int d);
    date_result_t r;
    r       = '0;
    r.year  = YEAR_W'(y);
    r.month = MON_W'(m);
    r.day   = DAY_W'(d);
    return r;
  endfunction

  function automatic date_result_t diff_out(int v);
    date_result_t r;
    r      = '0;
    r.diff = v[OFF_W-1:0];
    return r;
  endfunction

  function automatic date_result_t cmp_out(bit eq, bit gt);
    date_result_t r;
    r         = '0;
    r.equal   = eq;
    r.greater = gt;
    return r;
  endfunction

  function automatic date_result_t err_out();
    date_result_t r;
    r     = '0;
    r.err = 1'b1;
    return r;
  endfunction

  task automatic add_row(input logic [CMD_W-1:0] cmd, input date_t a, input date_t b,
                         input int off, input bit typed, input date_result_t want);
    directed_row_t row;
    row.req.cmd    = cmd;
    row.req.a      = a;
    row.req.b      = b;
    row.req.offset = off[OFF_W-1:0];
    row.typed      = typed;
    row.want       = want;
    directed_rows.push_back(row);
  endtask

  // ---------------------------------------------------------------- random requests

  function automatic date_t random_date();
    date_t d;
    int    y;
    int    m;
    case ($urandom_range(9))
      0:       y = $urandom_range(1, 3);
      1:       y = MAX_YEAR - $urandom_range(0, 2);
      default: y = $urandom_range(1, MAX_YEAR);
    endcase
    m = $urandom_range(1, 12);
    d = dt(y, m, $urandom_range(1, days_in_month(y, m)));
    return d;
  endfunction

  function automatic int random_offset();
    int v;
    case ($urandom_range(9))
      0, 1, 2, 3: v = int'($urandom_range(0, 800)) - 400;
      4, 5, 6:    v = int'($urandom_range(0, 120000)) - 60000;
      7, 8:       v = $urandom;
      default: begin
        case ($urandom_range(4))
          0:       v = DIFF_TOP;
          1:       v = DIFF_BOTTOM;
          2:       v = 3652058;
          3:       v = -3652058;
          default: v = 0;
        endcase
      end
    endcase
    return v;
  endfunction

  // spoil one field of a date so that it no longer names a real day
  function automatic date_t spoil_date(date_t d);
    date_t v;
    v = d;
    case ($urandom_range(5))
      0: v.day   = 5'd0;
      1: v.day   = DAY_W'($urandom_range(days_in_month(d.year, d.month) + 1, 31));
      2: v.month = 4'd0;
      3: v.month = MON_W'($urandom_range(13, 15));
      4: v.year  = '0;
      default: v.year = YEAR_W'($urandom_range(MAX_YEAR + 1, 16383));
    endcase
    return v;
  endfunction

  function automatic date_req_t random_request();
    date_req_t q;
    int        off;
    int        pick;
    pick     = $urandom_range(99);
    q.cmd    = CMD_W'($urandom_range(CMD_CMP));
    q.a      = random_date();
    q.b      = ($urandom_range(3) == 0) ? q.a : random_date();
    off      = random_offset();
    q.offset = off[OFF_W-1:0];
    if (pick < 10) begin
      // raw noise over every date and offset bit
      {q.a, q.b, q.offset} = (2 * $bits(date_t) + OFF_W)'({$urandom, $urandom, $urandom});
    end else if (pick < 20) begin
      if ($urandom_range(1) == 0) q.a = spoil_date(q.a);
      else q.b = spoil_date(q.b);
    end
    return q;
  endfunction

  // ---------------------------------------------------------------- stream driving

  // drain: hold valid low until every awaited result word has come back
  task automatic send_request(input date_req_t q, input date_result_t want, input bit drain);
    if (drain || ($urandom_range(99) < tx_idle_pct)) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
      while (drain && awaited_results.size() != 0) @(posedge clk_i);
      while ($urandom_range(99) < tx_idle_pct) @(posedge clk_i);
    end
    s_axis_tdata_i  <= {3'b000, q.offset, q.b.day, q.b.month, q.b.year,
                        q.a.day, q.a.month, q.a.year};
    s_axis_tuser_i  <= q.cmd;
    s_axis_tvalid_i <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    awaited_results.push_back(want);
  endtask

  // ---------------------------------------------------------------- result checking

  task automatic check_result();
    date_result_t got;
    date_result_t want;
    got.year    = m_axis_tdata_o[13:0];
    got.month   = m_axis_tdata_o[17:14];
    got.day     = m_axis_tdata_o[22:18];
    got.diff    = m_axis_tdata_o[45:23];
    got.equal   = m_axis_tdata_o[46];
    got.greater = m_axis_tdata_o[47];
    got.err     = m_axis_tuser_o;
    if (awaited_results.size() == 0) begin
      if (mismatch_count < REPORT_LIMIT)
        $display("unexpected result word: %0d-%0d-%0d diff %0d eq %0b gt %0b err %0b",
                 got.year, got.month, got.day, $signed(got.diff), got.equal, got.greater,
                 got.err);
      mismatch_count++;
    end else begin
      want = awaited_results.pop_front();
      if (got.year !== want.year || got.month !== want.month || got.day !== want.day
          || got.diff !== want.diff || got.equal !== want.equal
          || got.greater !== want.greater || got.err !== want.err) begin
        if (mismatch_count < REPORT_LIMIT) begin
          $display("mismatch: expected %0d-%0d-%0d diff %0d eq %0b gt %0b err %0b",
                   want.year, want.month, want.day, $signed(want.diff), want.equal,
                   want.greater, want.err);
          $display("          got      %0d-%0d-%0d diff %0d eq %0b gt %0b err %0b",
                   got.year, got.month, got.day, $signed(got.diff), got.equal,
                   got.greater, got.err);
        end
        mismatch_count++;
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) check_result();
    m_axis_tready_i <= ($urandom_range(99) >= rx_idle_pct);
  end

  // ---------------------------------------------------------------- stimulus

  initial begin
    date_req_t    q;
    date_result_t want;
    int           i;

    // directed table: edges of the year range, leap days, invalid dates, every command
    add_row(CMD_ADD,  dt(1, 1, 1),       dt(1, 1, 1), 0,           1'b1, date_out(1, 1, 1));
    add_row(CMD_ADD,  dt(9999, 12, 31),  dt(1, 1, 1), 1,           1'b1, err_out());
    add_row(CMD_SUB,  dt(1, 1, 1),       dt(1, 1, 1), 1,           1'b1, err_out());
    add_row(CMD_ADD,  dt(1, 1, 1),       dt(1, 1, 1), -1,          1'b1, err_out());
    add_row(CMD_SUB,  dt(1, 1, 1),       dt(1, 1, 1), -1,          1'b1, date_out(1, 1, 2));
    add_row(CMD_ADD,  dt(2000, 2, 28),   dt(1, 1, 1), 1,           1'b1, date_out(2000, 2, 29));
    add_row(CMD_ADD,  dt(1900, 2, 28),   dt(1, 1, 1), 1,           1'b1, date_out(1900, 3, 1));
    add_row(CMD_SUB,  dt(2024, 3, 1),    dt(1, 1, 1), 1,           1'b1, date_out(2024, 2, 29));
    add_row(CMD_ADD,  dt(1, 1, 1),       dt(1, 1, 1), DIFF_TOP,    1'b1, err_out());
    add_row(CMD_ADD,  dt(9999, 12, 31),  dt(1, 1, 1), DIFF_BOTTOM, 1'b1, err_out());
    add_row(CMD_SUB,  dt(9999, 12, 31),  dt(1, 1, 1), DIFF_TOP,    1'b1, err_out());
    add_row(CMD_ADD,  dt(1, 1, 1),       dt(1, 1, 1), 3652058,     1'b1,
            date_out(9999, 12, 31));
    add_row(CMD_SUB,  dt(9999, 12, 31),  dt(1, 1, 1), 3652058,     1'b1, date_out(1, 1, 1));
    add_row(CMD_ADD,  dt(0, 1, 1),       dt(1, 1, 1), 5,           1'b1, err_out());
    add_row(CMD_ADD,  dt(16383, 15, 31), dt(1, 1, 1), -1,          1'b1, err_out());
    add_row(CMD_ADD,  dt(2023, 2, 29),   dt(1, 1, 1), 1,           1'b1, err_out());
    add_row(CMD_SUB,  dt(2023, 0, 5),    dt(1, 1, 1), 1,           1'b1, err_out());
    add_row(CMD_DIFF, dt(9999, 12, 31),  dt(1, 1, 1), 0,           1'b1, diff_out(3652058));
    add_row(CMD_DIFF, dt(1, 1, 1),       dt(9999, 12, 31), 0,      1'b1, diff_out(-3652058));
    add_row(CMD_DIFF, dt(2024, 3, 1),    dt(2023, 3, 1), 0,        1'b1, diff_out(366));
    add_row(CMD_DIFF, dt(2023, 5, 1),    dt(2023, 4, 31), 0,       1'b1, err_out());
    add_row(CMD_CMP,  dt(2024, 2, 29),   dt(2024, 2, 29), 0,       1'b1, cmp_out(1'b1, 1'b0));
    add_row(CMD_CMP,  dt(2024, 3, 1),    dt(2024, 2, 29), 0,       1'b1, cmp_out(1'b0, 1'b1));
    add_row(CMD_CMP,  dt(2024, 2, 29),   dt(2024, 3, 1), 0,        1'b1, cmp_out(1'b0, 1'b0));
    add_row(CMD_CMP,  dt(2024, 1, 0),    dt(16383, 15, 31), 0,     1'b1, err_out());
    // a negative offset on subtract moves forward across a four-century boundary
    add_row(CMD_SUB,  dt(1999, 12, 31),  dt(1, 1, 1), -146098,    1'b0, '0);
    add_row(CMD_ADD,  dt(1600, 2, 29),   dt(1, 1, 1), 12345,       1'b0, '0);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[k]) begin
      want = directed_rows[k].typed ? directed_rows[k].want
                                    : calc_date_result(directed_rows[k].req);
      send_request(directed_rows[k].req, want, 1'b0);
    end

    for (i = 0; i < RANDOM_WORDS; i++) begin
      // a long stretch with both sides running flat out
      if (i == 500) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else if (i == 700) begin
        tx_idle_pct = 30;
        rx_idle_pct = 30;
      end
      q = random_request();
      send_request(q, calc_date_result(q), (i == 0) || (i == 300) || ($urandom_range(199) == 0));
    end
    s_axis_tvalid_i <= 1'b0;

    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("gregorian_date_arithmetic_tb OK");
    end else begin
      $display("gregorian_date_arithmetic_tb NOT OK");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin
    #12_000_000;
    $display("gregorian_date_arithmetic_tb NOT OK");
    $finish;
  end

endmodule

>>> sim.f
rtl/gda_pkg.sv
rtl/gda_ctrl.sv
rtl/gda_dp.sv
rtl/gregorian_date_arithmetic.sv
bench/gregorian_date_arithmetic_tb.sv
